FILE: rtl/asfd_pkg.sv
// Package for the actuator slew and fan delay block.
// Holds the field limits, reciprocal constants and microcode types, plus the control store.
// No dependencies.
package asfd_pkg;

    // Field limits used for saturation and output scaling.
    localparam logic [13:0] THROTTLE_MAX = 14'd10000;
    localparam logic [14:0] SPEED_MAX    = 15'd30000;
    localparam logic [10:0] TORQUE_MAX   = 11'd2000;
    localparam logic [16:0] TIMER_MAX    = 17'd131071;
    localparam logic [14:0] CURR_BASE    = 15'd4000;

    localparam int FAN_COUNT = 3;

    // Configuration register map.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE_RATE = 2'd0,
        CFG_SPEED_ACCEL   = 2'd1,
        CFG_TORQUE_SLEW   = 2'd2,
        CFG_FAN_DELAY     = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] THROTTLE_RATE_RST = 16'd5000;
    localparam logic [15:0] SPEED_ACCEL_RST   = 16'd5000;
    localparam logic [15:0] TORQUE_SLEW_RST   = 16'd1000;
    localparam logic [15:0] FAN_DELAY_RST     = 16'd2000;

    // Multiplier operand widths. Operand A carries products of rate times time
    // (below 2^26); operand B carries the reciprocal constants (27 bits).
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Exact division by a constant: floor(x / d) = (x * ceil(2^s / d)) >> s,
    // with s = (dividend width) + ceil(log2(d)).
    localparam int SH_DIV1000  = 36;
    localparam int SH_DIV10000 = 40;
    localparam int SH_DIV3     = 17;
    localparam longint RECIP_1000_L  = ((64'd1 << SH_DIV1000) + 64'd999) / 64'd1000;
    localparam longint RECIP_10000_L = ((64'd1 << SH_DIV10000) + 64'd9999) / 64'd10000;
    localparam longint RECIP_3_L     = ((64'd1 << SH_DIV3) + 64'd2) / 64'd3;
    localparam logic [MUL_B_W-1:0] RECIP_1000  = MUL_B_W'(RECIP_1000_L);
    localparam logic [MUL_B_W-1:0] RECIP_10000 = MUL_B_W'(RECIP_10000_L);
    localparam logic [MUL_B_W-1:0] RECIP_3     = MUL_B_W'(RECIP_3_L);
    localparam logic [MUL_B_W-1:0] PWM_FULL    = MUL_B_W'(4095);

    // Microcode fields.
    typedef enum logic [2:0] {
        A_THR_RATE,
        A_MODE_RATE,
        A_TMP,
        A_THR_POS,
        A_SPEED
    } a_sel_t;

    typedef enum logic [2:0] {
        B_MS,
        B_R1000,
        B_R10000,
        B_PWM_FULL,
        B_R3
    } b_sel_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_17,
        SH_36,
        SH_40
    } shr_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_TMP,
        D_STEP,
        D_PWM,
        D_VOLT
    } dst_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_LATCH,
        ALU_APPLY_THR,
        ALU_APPLY_DYNO,
        ALU_FINISH
    } alu_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_WAIT_IN,
        JMP_IF_TORQUE,
        JMP_WAIT_OUT
    } jmp_t;

    typedef logic [3:0] pc_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        shr_t   shr;
        dst_t   dst;
        alu_t   alu;
        jmp_t   jmp;
        pc_t    target;
    } ucode_t;

    // Program addresses that are jump targets.
    localparam pc_t PC_WAIT = 4'd0;
    localparam pc_t PC_OUT  = 4'd10;

    // Control store. One word per step of the tick program.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        w = '{a_sel: A_TMP, b_sel: B_MS, shr: SH_NONE, dst: D_NONE,
              alu: ALU_NONE, jmp: JMP_ALWAYS, target: PC_WAIT};
        case (pc)
            4'd0: begin
                w.alu = ALU_LATCH;
                w.jmp = JMP_WAIT_IN;
            end
            4'd1: begin
                w.a_sel = A_THR_RATE;
                w.b_sel = B_MS;
                w.dst   = D_TMP;
                w.jmp   = JMP_NEXT;
            end
            4'd2: begin
                w.a_sel = A_TMP;
                w.b_sel = B_R1000;
                w.shr   = SH_36;
                w.dst   = D_STEP;
                w.jmp   = JMP_NEXT;
            end
            4'd3: begin
                w.alu = ALU_APPLY_THR;
                w.jmp = JMP_NEXT;
            end
            4'd4: begin
                w.a_sel = A_MODE_RATE;
                w.b_sel = B_MS;
                w.dst   = D_TMP;
                w.jmp   = JMP_NEXT;
            end
            4'd5: begin
                w.a_sel = A_TMP;
                w.b_sel = B_R1000;
                w.shr   = SH_36;
                w.dst   = D_STEP;
                w.jmp   = JMP_NEXT;
            end
            4'd6: begin
                w.alu = ALU_APPLY_DYNO;
                w.jmp = JMP_NEXT;
            end
            4'd7: begin
                w.a_sel = A_THR_POS;
                w.b_sel = B_PWM_FULL;
                w.dst   = D_TMP;
                w.jmp   = JMP_NEXT;
            end
            4'd8: begin
                w.a_sel  = A_TMP;
                w.b_sel  = B_R10000;
                w.shr    = SH_40;
                w.dst    = D_PWM;
                w.jmp    = JMP_IF_TORQUE;
                w.target = PC_OUT;
            end
            4'd9: begin
                w.a_sel = A_SPEED;
                w.b_sel = B_R3;
                w.shr   = SH_17;
                w.dst   = D_VOLT;
                w.jmp   = JMP_NEXT;
            end
            4'd10: begin
                w.alu    = ALU_FINISH;
                w.jmp    = JMP_WAIT_OUT;
                w.target = PC_WAIT;
            end
            default: begin
                w.jmp    = JMP_ALWAYS;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/actuator_slew_and_fan_delay.sv
// Top level of the actuator slew and fan delay block: a microcoded sequencer over one
// shared multiplier that slews the throttle and dyno setpoints and runs the fan delay timers.
// Depends on asfd_pkg for constants, microcode types and the control store.
//
// Each accepted input transaction runs through the program: throttle step and update, dyno
// step and update, PWM duty, output voltage (spin mode only) and finish, where the result is
// registered once the output register is free. A new transaction is taken only after the
// previous one has finished, one at a time over the single shared 26x27 multiplier.
// Reset: rst_n is asynchronous and active low; it restores the register defaults, parks the
// actuators at zero, clears all fan timers and turns every fan off.
module actuator_slew_and_fan_delay (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [13:0]                   throttle_target,
    input  logic                          spin_mode,
    input  logic [14:0]                   speed_target,
    input  logic [10:0]                   torque_target,
    input  logic                          engine_fan_cmd,
    input  logic                          dyno_fan_cmd,
    input  logic                          resistor_fan_cmd,
    input  logic [9:0]                    elapsed_ms,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [13:0]                   throttle_now,
    output logic [11:0]                   pwm_duty,
    output logic                          spin_mode_out,
    output logic [14:0]                   speed_now,
    output logic [10:0]                   torque_now,
    output logic [13:0]                   speed_volt_mv,
    output logic [14:0]                   torque_curr_ua,
    output logic                          eng_fan_on,
    output logic                          dyno_fan_on,
    output logic                          res_fan_on,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [asfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import asfd_pkg::*;

    // Configuration registers.
    logic [15:0] throttle_rate_reg;
    logic [15:0] speed_accel_reg;
    logic [15:0] torque_slew_reg;
    logic [15:0] fan_delay_reg;

    // Sequencer state.
    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t uw;

    // Latched transaction fields, saturated to their ranges on capture.
    logic [13:0]          thr_tgt_reg;
    logic [14:0]          spd_tgt_reg;
    logic [10:0]          trq_tgt_reg;
    logic                 spin_reg;
    logic [9:0]           ms_reg;
    logic [FAN_COUNT-1:0] fan_cmd_reg;
    logic [FAN_COUNT-1:0] fan_cmd_in;

    // Datapath registers.
    logic [MUL_A_W-1:0] tmp_reg;
    logic [16:0]        step_reg;
    logic [11:0]        pwm_reg;
    logic [13:0]        volt_reg;

    // Actuator and fan state.
    logic [13:0]          thr_pos_reg;
    logic [14:0]          speed_reg;
    logic [10:0]          torque_reg;
    logic [16:0]          fan_timer_reg [FAN_COUNT];
    logic [16:0]          fan_timer_next [FAN_COUNT];
    logic [FAN_COUNT-1:0] fan_state_reg;
    logic [FAN_COUNT-1:0] fan_state_next;

    // Output register.
    logic out_valid_reg;

    // Multiplier and shifter.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_shr;

    logic in_fire;
    logic out_free;
    logic finish_fire;
    logic [14:0] curr_val;

    // Move pos toward goal by at most step; values never exceed 15 bits.
    function automatic logic [14:0] approach(input logic [14:0] pos, input logic [14:0] goal,
                                             input logic [16:0] step);
        logic [14:0] diff;
        logic [16:0] moved;
        begin
            if (goal >= pos) begin
                diff  = goal - pos;
                moved = 17'(pos) + step;
            end else begin
                diff  = pos - goal;
                moved = 17'(pos) - step;
            end
            if (17'(diff) <= step) begin
                return goal;
            end
            return moved[14:0];
        end
    endfunction

    // The control word for the current step comes straight from the control store.
    assign uw = ucode_rom(pc_reg);

    // Input transactions are taken only while the program sits at its wait step.
    assign in_stall    = (uw.jmp != JMP_WAIT_IN);
    assign in_fire     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign finish_fire = (uw.alu == ALU_FINISH) && out_free;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;

    // Step counter with conditional jumps.
    always_comb
    begin
        case (uw.jmp)
            JMP_NEXT:      pc_next = pc_reg + 4'd1;
            JMP_ALWAYS:    pc_next = uw.target;
            JMP_WAIT_IN:   pc_next = in_fire ? pc_reg + 4'd1 : pc_reg;
            JMP_IF_TORQUE: pc_next = spin_reg ? pc_reg + 4'd1 : uw.target;
            JMP_WAIT_OUT:  pc_next = out_free ? uw.target : pc_reg;
            default:       pc_next = PC_WAIT;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (uw.a_sel)
            A_THR_RATE:  mul_a = MUL_A_W'(throttle_rate_reg);
            A_MODE_RATE: mul_a = spin_reg ? MUL_A_W'(speed_accel_reg) : MUL_A_W'(torque_slew_reg);
            A_TMP:       mul_a = tmp_reg;
            A_THR_POS:   mul_a = MUL_A_W'(thr_pos_reg);
            A_SPEED:     mul_a = MUL_A_W'(speed_reg);
            default:     mul_a = '0;
        endcase
        case (uw.b_sel)
            B_MS:       mul_b = MUL_B_W'(ms_reg);
            B_R1000:    mul_b = RECIP_1000;
            B_R10000:   mul_b = RECIP_10000;
            B_PWM_FULL: mul_b = PWM_FULL;
            B_R3:       mul_b = RECIP_3;
            default:    mul_b = '0;
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The shift completes a division by a constant through its reciprocal.
    always_comb
    begin
        case (uw.shr)
            SH_NONE: prod_shr = prod;
            SH_17:   prod_shr = prod >> SH_DIV3;
            SH_36:   prod_shr = prod >> SH_DIV1000;
            SH_40:   prod_shr = prod >> SH_DIV10000;
            default: prod_shr = prod;
        endcase
    end

    // Fan commands in fan order; fans beyond the three commanded ones see off.
    always_comb
    begin
        for (int k = 0; k < FAN_COUNT; k++) begin
            fan_cmd_in[k] = 1'b0;
        end
        fan_cmd_in[0] = engine_fan_cmd;
        if (FAN_COUNT > 1) begin
            fan_cmd_in[1 % FAN_COUNT] = dyno_fan_cmd;
        end
        if (FAN_COUNT > 2) begin
            fan_cmd_in[2 % FAN_COUNT] = resistor_fan_cmd;
        end
    end

    // Fan delay timers. A differing command accumulates time, saturating, and switches the
    // fan once the delay is reached; an agreeing command clears the timer.
    always_comb
    begin
        logic [17:0] t_sum;
        logic [16:0] t_sat;
        t_sum = '0;
        t_sat = '0;
        for (int k = 0; k < FAN_COUNT; k++) begin
            fan_state_next[k] = fan_state_reg[k];
            fan_timer_next[k] = 17'd0;
            if (fan_cmd_reg[k] != fan_state_reg[k]) begin
                t_sum = 18'(fan_timer_reg[k]) + 18'(ms_reg);
                t_sat = (t_sum > 18'(TIMER_MAX)) ? TIMER_MAX : t_sum[16:0];
                if (t_sat >= 17'(fan_delay_reg)) begin
                    fan_state_next[k] = fan_cmd_reg[k];
                    fan_timer_next[k] = 17'd0;
                end else begin
                    fan_timer_next[k] = t_sat;
                end
            end
        end
    end

    // The torque loop sits at its 4 mA floor in spin mode.
    assign curr_val = spin_reg ? CURR_BASE : CURR_BASE + {1'b0, torque_reg, 3'b000};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            throttle_rate_reg <= THROTTLE_RATE_RST;
            speed_accel_reg   <= SPEED_ACCEL_RST;
            torque_slew_reg   <= TORQUE_SLEW_RST;
            fan_delay_reg     <= FAN_DELAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_THROTTLE_RATE: throttle_rate_reg <= cfg_data;
                CFG_SPEED_ACCEL:   speed_accel_reg   <= cfg_data;
                CFG_TORQUE_SLEW:   torque_slew_reg   <= cfg_data;
                CFG_FAN_DELAY:     fan_delay_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer, actuator state and fan state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg        <= PC_WAIT;
            thr_pos_reg   <= '0;
            speed_reg     <= '0;
            torque_reg    <= '0;
            fan_state_reg <= '0;
            for (int k = 0; k < FAN_COUNT; k++) begin
                fan_timer_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (uw.alu == ALU_APPLY_THR) begin
                thr_pos_reg <= 14'(approach({1'b0, thr_pos_reg}, {1'b0, thr_tgt_reg}, step_reg));
            end
            if (uw.alu == ALU_APPLY_DYNO) begin
                if (spin_reg) begin
                    speed_reg  <= approach(speed_reg, spd_tgt_reg, step_reg);
                    torque_reg <= '0;
                end else begin
                    torque_reg <= 11'(approach(15'(torque_reg), 15'(trq_tgt_reg), step_reg));
                    speed_reg  <= '0;
                end
            end
            if (finish_fire) begin
                fan_state_reg <= fan_state_next;
                for (int k = 0; k < FAN_COUNT; k++) begin
                    fan_timer_reg[k] <= fan_timer_next[k];
                end
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction capture and datapath registers.
    always_ff @(posedge clk)
    begin
        if ((uw.alu == ALU_LATCH) && in_fire) begin
            thr_tgt_reg <= (throttle_target > THROTTLE_MAX) ? THROTTLE_MAX : throttle_target;
            spd_tgt_reg <= (speed_target > SPEED_MAX) ? SPEED_MAX : speed_target;
            trq_tgt_reg <= (torque_target > TORQUE_MAX) ? TORQUE_MAX : torque_target;
            spin_reg    <= spin_mode;
            ms_reg      <= elapsed_ms;
            fan_cmd_reg <= fan_cmd_in;
        end
        case (uw.dst)
            D_TMP:   tmp_reg  <= prod_shr[MUL_A_W-1:0];
            D_STEP:  step_reg <= prod_shr[16:0];
            D_PWM:   pwm_reg  <= prod_shr[11:0];
            D_VOLT:  volt_reg <= prod_shr[13:0];
            default: ;
        endcase
        // Torque mode skips the voltage step, so the voltage is zeroed when the dyno
        // state is updated.
        if ((uw.alu == ALU_APPLY_DYNO) && !spin_reg) begin
            volt_reg <= '0;
        end
        if (finish_fire) begin
            throttle_now    <= thr_pos_reg;
            pwm_duty        <= pwm_reg;
            spin_mode_out   <= spin_reg;
            speed_now       <= speed_reg;
            torque_now      <= torque_reg;
            speed_volt_mv   <= volt_reg;
            torque_curr_ua  <= curr_val;
            eng_fan_on      <= fan_state_next[0];
            dyno_fan_on     <= (FAN_COUNT > 1) ? fan_state_next[1 % FAN_COUNT] : 1'b0;
            res_fan_on      <= (FAN_COUNT > 2) ? fan_state_next[2 % FAN_COUNT] : 1'b0;
        end
    end

endmodule
